/* src/assert_macros.svh */
// Assertion macros shared by the checker files.
// No dependencies; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define ASSERT_IMPLIES(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

/* src/pihc_pkg.sv */
// Shared types, constants and a clamp helper for the PI heater controller.
// No dependencies.
package pihc_pkg;

   localparam int DriveWidth = 14;

   localparam logic [7:0] TARGET_RESET   = 8'd0;
   localparam logic [7:0] PGAIN_RESET    = 8'd10;
   localparam logic [7:0] IGAIN_RESET    = 8'd1;
   localparam logic [7:0] CRITICAL_RESET = 8'd120;

   typedef enum logic [1:0] {
      CSR_TARGET   = 2'd0,
      CSR_PGAIN    = 2'd1,
      CSR_IGAIN    = 2'd2,
      CSR_CRITICAL = 2'd3
   } csr_index_type;

   typedef enum logic [1:0] {
      STATUS_OFF   = 2'd0,
      STATUS_ON    = 2'd1,
      STATUS_ERROR = 2'd2
   } status_type;

   typedef struct packed {
      logic [7:0]        target;
      logic signed [7:0] prop_gain;
      logic signed [7:0] int_gain;
      logic [7:0]        critical;
   } cfg_type;

   typedef struct packed {
      logic                         heater;
      logic                         lamp;
      logic                         manual;
      logic                         halted;
      status_type                   status;
      logic signed [DriveWidth-1:0] integral;
      logic signed [DriveWidth-1:0] drive;
   } state_type;

   // limit of +-256 degrees in 1/16 degree units
   localparam logic signed [26:0] CLAMP_POS = 27'sd4096;
   localparam logic signed [26:0] CLAMP_NEG = -27'sd4096;

   function automatic logic signed [DriveWidth-1:0] clamp_wide(input logic signed [26:0] v);
      logic signed [DriveWidth-1:0] r;
      if (v > CLAMP_POS) begin
         r = DriveWidth'(CLAMP_POS);
      end else if (v < CLAMP_NEG) begin
         r = DriveWidth'(CLAMP_NEG);
      end else begin
         r = DriveWidth'(v);
      end
      return r;
   endfunction

endpackage

/* src/pihc_step.sv */
// One controller step: next state from current state, configuration and item.
// Depends on pihc_pkg.
module pihc_step (
   input  logic                 action,
   input  logic signed [15:0]   raw_temperature,
   input  pihc_pkg::cfg_type    cfg,
   input  pihc_pkg::state_type  cur,
   output pihc_pkg::state_type  nxt
);

   logic signed [16:0] setpoint;
   logic signed [16:0] raw_x;
   logic signed [16:0] err;
   logic signed [17:0] sum;
   logic signed [24:0] prod_p;
   logic signed [25:0] prod_i;
   logic signed [26:0] drive_raw;
   logic signed [13:0] drive_cl;
   logic               over_limit;

   assign setpoint  = $signed({5'b0, cfg.target, 4'b0});
   assign raw_x     = 17'(raw_temperature);
   assign err       = setpoint - raw_x;
   assign sum       = 18'(cur.integral) + 18'(err);
   assign prod_p    = 25'(cfg.prop_gain) * 25'(err);
   assign prod_i    = 26'(cfg.int_gain) * 26'(sum);
   assign drive_raw = 27'(prod_p) + 27'(prod_i);
   assign drive_cl  = pihc_pkg::clamp_wide(drive_raw);

   assign over_limit = raw_x > $signed({5'b0, cfg.critical, 4'b0});

   always_comb begin
      nxt = cur;
      if (action) begin
         // leaving manual mode also resumes halted control
         if (cur.manual) begin
            nxt.manual = 1'b0;
            nxt.halted = 1'b0;
         end else begin
            nxt.manual = 1'b1;
         end
         nxt.heater = ~cur.heater;
         nxt.status = cur.heater ? pihc_pkg::STATUS_OFF : pihc_pkg::STATUS_ON;
         nxt.lamp   = ~cur.lamp;
      end else if (over_limit) begin
         nxt.halted = 1'b1;
         nxt.heater = 1'b0;
         nxt.status = pihc_pkg::STATUS_ERROR;
         nxt.lamp   = 1'b1;
      end else if (!cur.halted && !cur.manual) begin
         nxt.integral = pihc_pkg::clamp_wide(27'(sum));
         nxt.drive    = drive_cl;
         nxt.heater   = drive_cl > 14'sd0;
         nxt.status   = (drive_cl > 14'sd0) ? pihc_pkg::STATUS_ON : pihc_pkg::STATUS_OFF;
      end
   end

endmodule

/* src/pi_heater_control_with_cutoff.sv */
// PI heater controller with over-temperature cutoff, top level.
// A request waits in the input register; the controller state updates in one
// pass from it when the output is free. Throughput: one item per cycle while
// the output is not stalled; the state register doubles as result register.
// Reset (synchronous, active high) restores register defaults and clears state.
// Depends on pihc_pkg and pihc_step.
module pi_heater_control_with_cutoff (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [15:0] req_tdata,   // [15:0] raw_temperature
   input  logic [0:0]  req_tuser,   // [0] action
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata,   // [0] heater_on, [14:1] drive_value,
                                    // [16:15] heat_status, [17] manual_active,
                                    // [18] warning_lamp, [23:19] zero
   input  logic        csr_we,
   input  logic [1:0]  csr_index,
   input  logic [7:0]  csr_wdata
);

   pihc_pkg::cfg_type   cfg_ff;
   pihc_pkg::state_type st_ff;
   pihc_pkg::state_type st_in;

   logic               in_valid_ff;
   logic               in_valid_in;
   logic               in_action_ff;
   logic signed [15:0] in_raw_ff;
   logic               rsp_valid_ff;
   logic               rsp_valid_in;
   logic               advance;
   logic               req_xfer;

   assign advance    = in_valid_ff && (!rsp_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || advance;
   assign req_xfer   = req_tvalid && req_tready;

   assign in_valid_in  = req_xfer ? 1'b1 : (advance ? 1'b0 : in_valid_ff);
   assign rsp_valid_in = advance ? 1'b1 : (rsp_tready ? 1'b0 : rsp_valid_ff);

   pihc_step u_step (
      .action          (in_action_ff),
      .raw_temperature (in_raw_ff),
      .cfg             (cfg_ff),
      .cur             (st_ff),
      .nxt             (st_in)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.target    <= pihc_pkg::TARGET_RESET;
         cfg_ff.prop_gain <= pihc_pkg::PGAIN_RESET;
         cfg_ff.int_gain  <= pihc_pkg::IGAIN_RESET;
         cfg_ff.critical  <= pihc_pkg::CRITICAL_RESET;
      end else if (csr_we) begin
         unique case (pihc_pkg::csr_index_type'(csr_index))
            pihc_pkg::CSR_TARGET:   cfg_ff.target    <= csr_wdata;
            pihc_pkg::CSR_PGAIN:    cfg_ff.prop_gain <= csr_wdata;
            pihc_pkg::CSR_IGAIN:    cfg_ff.int_gain  <= csr_wdata;
            pihc_pkg::CSR_CRITICAL: cfg_ff.critical  <= csr_wdata;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         st_ff        <= '0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         if (advance) begin
            st_ff <= st_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_xfer) begin
         in_action_ff <= req_tuser[0];
         in_raw_ff    <= req_tdata;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {5'b0, st_ff.lamp, st_ff.manual, st_ff.status,
                        st_ff.drive, st_ff.heater};

endmodule

/* src/pihc_checker.sv */
// Port-level checks for the PI heater controller, bound to the top level.
// Depends on assert_macros.svh and pihc_pkg.
`include "assert_macros.svh"

module pihc_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [23:0] rsp_tdata
);

   `ASSERT_NEXT(rsp_hold_a, clock, reset, rsp_tvalid && !rsp_tready,
      rsp_tvalid && $stable(rsp_tdata), "stalled result changed")

   `ASSERT_IMPLIES(heater_status_a, clock, reset, rsp_tvalid,
      rsp_tdata[0] == (rsp_tdata[16:15] == pihc_pkg::STATUS_ON),
      "heater level and status disagree")

   `ASSERT_IMPLIES(error_lamp_a, clock, reset,
      rsp_tvalid && rsp_tdata[16:15] == pihc_pkg::STATUS_ERROR,
      rsp_tdata[18] && !rsp_tdata[0], "error status without lamp or with heater")

   `ASSERT_IMPLIES(drive_range_a, clock, reset, rsp_tvalid,
      !(rsp_tdata[14] && !rsp_tdata[13]) &&
      !(!rsp_tdata[14] && rsp_tdata[13] && rsp_tdata[12:1] != 12'd0),
      "drive outside clamp range")

endmodule

bind pi_heater_control_with_cutoff pihc_checker u_pihc_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);
